@@ hw/rtl/fcf_pkg.sv @@
// shared types, register codes and crc helper for the byte-stuffing framer
`default_nettype none

package fcf_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_FLAG_VALUE    = 3'd0;
  localparam logic [2:0] CFG_ESCAPE_VALUE  = 3'd1;
  localparam logic [2:0] CFG_ESCAPE_MASK   = 3'd2;
  localparam logic [2:0] CFG_CRC_POLY      = 3'd3;
  localparam logic [2:0] CFG_CRC_BIG_END   = 3'd4;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // reset values of the configuration registers
  localparam logic [7:0]  RST_FLAG_VALUE   = 8'h7E;
  localparam logic [7:0]  RST_ESCAPE_VALUE = 8'h7D;
  localparam logic [7:0]  RST_ESCAPE_MASK  = 8'h20;
  localparam logic [15:0] RST_CRC_POLY     = 16'h1021;
  localparam logic        RST_CRC_BIG_END  = 1'b0;

  // queue depth between front and back
  localparam int unsigned DEF_QUEUE_DEPTH = 4;

  // live configuration seen by the front and the back
  typedef struct packed {
    logic [7:0]  flag_value;
    logic [7:0]  escape_value;
    logic [7:0]  escape_mask;
    logic [15:0] crc_polynomial;
    logic        crc_big_endian;
  } fcf_cfg_t;

  // one classified input transaction
  typedef struct packed {
    logic        open;   // frame opens with this byte
    logic        last;   // frame closes after this byte
    logic [7:0]  data;
    logic [15:0] crc;    // crc including this byte
  } fcf_job_t;

  // queue status towards both sides
  typedef struct packed {
    logic empty;
    logic full;
  } fcf_qstat_t;

  // output sequencer steps
  typedef enum logic [2:0] {
    STEP_FIRST,
    STEP_OPEN,
    STEP_DATA,
    STEP_CRC1,
    STEP_CRC2,
    STEP_CLOSE
  } fcf_step_t;

  // fold one byte into the crc, msb first
  function automatic logic [15:0] fcf_crc_fold(input logic [15:0] crc,
                                               input logic [7:0]  b,
                                               input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fcf_front.sv @@
// front end: accepts payload bytes, tracks the open frame and the running crc
`default_nettype none

module fcf_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,
  input  wire logic              in_tlast,
  input  wire fcf_pkg::fcf_cfg_t cfg,
  input  wire fcf_pkg::fcf_qstat_t qstat,
  output logic                   push,
  output fcf_pkg::fcf_job_t      job
);
  import fcf_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic        in_frame_r, in_frame_nxt;
  logic [15:0] crc_base;

  // take a transaction whenever the queue has room
  assign in_tready = !qstat.full;
  assign push      = in_tvalid && in_tready;

  // classify and fold the byte into the crc
  assign crc_base = in_frame_r ? crc_r : 16'h0000;

  always_comb begin
    job.open = !in_frame_r;
    job.last = in_tlast;
    job.data = in_tdata;
    job.crc  = fcf_crc_fold(crc_base, in_tdata, cfg.crc_polynomial);
  end

  always_comb begin
    crc_nxt      = crc_r;
    in_frame_nxt = in_frame_r;
    if (push) begin
      crc_nxt      = job.crc;
      in_frame_nxt = !in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= 16'h0000;
      in_frame_r <= 1'b0;
    end else begin
      crc_r      <= crc_nxt;
      in_frame_r <= in_frame_nxt;
    end
  end

  // a closing byte leaves no frame open
  a_close_frame: assert property (@(posedge clk) disable iff (!rst_n)
    push && in_tlast |=> !in_frame_r)
    else $error("frame still open after closing byte");

endmodule

`default_nettype wire

@@ hw/rtl/fcf_queue.sv @@
// short queue of classified transactions between front and back
`default_nettype none

module fcf_queue #(
  parameter int unsigned DEPTH = fcf_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire fcf_pkg::fcf_job_t   push_job,
  input  wire logic                pop,
  output fcf_pkg::fcf_job_t        head,
  output fcf_pkg::fcf_qstat_t      qstat
);
  import fcf_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  fcf_job_t        slot_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign qstat.empty = (count_r == '0);
  assign qstat.full  = (count_r == CW'(DEPTH));
  assign head        = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // no write into a full queue, no read from an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && qstat.full) && !(pop && qstat.empty))
    else $error("queue overflow or underflow");

endmodule

`default_nettype wire

@@ hw/rtl/fcf_back.sv @@
// back end: expands queued transactions into flags, stuffed bytes and crc
`default_nettype none

module fcf_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fcf_pkg::fcf_cfg_t   cfg,
  input  wire fcf_pkg::fcf_job_t   head,
  input  wire fcf_pkg::fcf_qstat_t qstat,
  output logic                     pop,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [7:0]               out_tdata,
  output logic                     out_tuser,
  output logic                     out_tlast
);
  import fcf_pkg::*;

  fcf_step_t   step_r, step_nxt, cur_step;
  logic        esc_pend_r, esc_pend_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic        out_end_r, out_end_nxt;
  logic        out_last_r, out_last_nxt;
  logic        can_emit, emit, done;
  logic [7:0]  sel_byte;
  logic        hit;

  assign can_emit = !out_valid_r || out_tready;
  assign emit     = can_emit && !qstat.empty;
  assign pop      = emit && done;

  // the first step of a fresh transaction depends on whether it opens a frame
  assign cur_step = (step_r == STEP_FIRST) ? (head.open ? STEP_OPEN : STEP_DATA) : step_r;

  // byte subject to stuffing in this step
  always_comb begin
    case (cur_step)
      STEP_CRC1: sel_byte = cfg.crc_big_endian ? head.crc[15:8] : head.crc[7:0];
      STEP_CRC2: sel_byte = cfg.crc_big_endian ? head.crc[7:0] : head.crc[15:8];
      default:   sel_byte = head.data;
    endcase
  end

  assign hit = (sel_byte == cfg.flag_value) || (sel_byte == cfg.escape_value);

  // next step
  always_comb begin
    step_nxt     = step_r;
    esc_pend_nxt = esc_pend_r;
    done         = 1'b0;
    case (cur_step)
      STEP_OPEN: begin
        step_nxt = STEP_DATA;
      end
      STEP_DATA, STEP_CRC1, STEP_CRC2: begin
        if (hit && !esc_pend_r) begin
          esc_pend_nxt = 1'b1;
          step_nxt     = cur_step;
        end else begin
          esc_pend_nxt = 1'b0;
          case (cur_step)
            STEP_DATA: begin
              if (head.last) begin
                step_nxt = STEP_CRC1;
              end else begin
                step_nxt = STEP_FIRST;
                done     = 1'b1;
              end
            end
            STEP_CRC1: step_nxt = STEP_CRC2;
            default:   step_nxt = STEP_CLOSE;
          endcase
        end
      end
      STEP_CLOSE: begin
        step_nxt = STEP_FIRST;
        done     = 1'b1;
      end
      default: begin
        step_nxt = STEP_FIRST;
      end
    endcase
    if (!emit) begin
      step_nxt     = step_r;
      esc_pend_nxt = esc_pend_r;
    end
  end

  // output byte of this step
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_end_nxt   = out_end_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_end_nxt   = 1'b0;
      out_last_nxt  = 1'b0;
      case (cur_step)
        STEP_OPEN: begin
          out_data_nxt = cfg.flag_value;
        end
        STEP_DATA, STEP_CRC1, STEP_CRC2: begin
          if (hit && !esc_pend_r) begin
            out_data_nxt = cfg.escape_value;
          end else begin
            out_data_nxt = esc_pend_r ? (sel_byte ^ cfg.escape_mask) : sel_byte;
            out_last_nxt = (cur_step == STEP_DATA) && !head.last;
          end
        end
        STEP_CLOSE: begin
          out_data_nxt = cfg.flag_value;
          out_end_nxt  = 1'b1;
          out_last_nxt = 1'b1;
        end
        default: begin
          out_data_nxt = cfg.flag_value;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_FIRST;
      esc_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      esc_pend_r  <= esc_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_end_r  <= out_end_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_end_r;
  assign out_tlast  = out_last_r;

  // the closing flag always ends the run of its transaction
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame end without end of run");

  // a pending escape only lives in a stuffed step
  a_esc_step: assert property (@(posedge clk) disable iff (!rst_n)
    esc_pend_r |-> (step_r == STEP_DATA || step_r == STEP_CRC1 || step_r == STEP_CRC2))
    else $error("escape pending outside stuffed step");

endmodule

`default_nettype wire

@@ hw/rtl/crc16_byte_stuffing_framer.sv @@
// top level of the byte-stuffing framer with crc-16 and configuration registers
//
// Input channel in_*: one payload byte per transaction in in_tdata[7:0],
// in_tlast marks the final byte of a packet. Output channel out_*: one line
// byte per transaction in out_tdata[7:0], out_tuser high on the closing flag,
// out_tlast high on the final line byte caused by an input transaction.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 flag,
// 1 escape, 2 mask, 3 polynomial, 4 crc byte order) at the clock edge.
// An input is written into the queue, then its first line byte is registered
// in the output register behind out_tvalid, which sends one line byte per
// cycle while out_tready is high. An input yields 1 to 8 line bytes: 1 for a
// plain byte, 2 for an escaped byte, plus one for an opening flag and up to
// five for the crc and closing flag. The front takes a transaction every cycle
// while the queue of QUEUE_DEPTH entries has room.
// Reset: registers return to their defaults, no frame is open, the queue and
// output register are empty. When out_tready is low the output byte holds,
// the queue fills and in_tready drops once it is full.
`default_nettype none

module crc16_byte_stuffing_framer #(
  parameter int unsigned QUEUE_DEPTH = fcf_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,   // [7:0] payload_byte
  input  wire logic                             in_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [7:0]                            out_tdata,  // [7:0] line_byte
  output logic                                  out_tuser,  // [0] frame_end
  output logic                                  out_tlast,
  input  wire logic                             cfg_we,
  input  wire logic [fcf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [fcf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import fcf_pkg::*;

  fcf_cfg_t   cfg_r, cfg_nxt;
  fcf_job_t   push_job, head;
  fcf_qstat_t qstat;
  logic       push, pop;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FLAG_VALUE:   cfg_nxt.flag_value     = cfg_wdata[7:0];
        CFG_ESCAPE_VALUE: cfg_nxt.escape_value   = cfg_wdata[7:0];
        CFG_ESCAPE_MASK:  cfg_nxt.escape_mask    = cfg_wdata[7:0];
        CFG_CRC_POLY:     cfg_nxt.crc_polynomial = cfg_wdata[15:0];
        CFG_CRC_BIG_END:  cfg_nxt.crc_big_endian = cfg_wdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_value     <= RST_FLAG_VALUE;
      cfg_r.escape_value   <= RST_ESCAPE_VALUE;
      cfg_r.escape_mask    <= RST_ESCAPE_MASK;
      cfg_r.crc_polynomial <= RST_CRC_POLY;
      cfg_r.crc_big_endian <= RST_CRC_BIG_END;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fcf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg       (cfg_r),
    .qstat     (qstat),
    .push      (push),
    .job       (push_job)
  );

  fcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  fcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

@@ tb/tb_crc16_byte_stuffing_framer.sv @@
// self-checking testbench for the crc-16 byte-stuffing framer
module tb_crc16_byte_stuffing_framer;
  import fcf_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int ITEMS_PER_PHASE = 55;

  // register indexes that the block does not implement
  localparam logic [2:0] CFG_SPARE_LO = 3'd5;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  // one row of directed stimulus; typed holds known line bytes, first byte lowest
  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  data;
    logic        last;
    logic [2:0]  idx;
    logic [15:0] val;
    logic [2:0]  n_typed;
    logic [31:0] typed;
  } stim_row_t;

  // one line byte as it should leave the block
  typedef struct packed {
    logic [7:0] line_byte;
    logic       frame_end;
    logic       last_of_run;
  } line_rec_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;   // [7:0] payload_byte
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [7:0] out_tdata;  // [7:0] line_byte
  logic out_tuser;        // [0] frame_end
  logic out_tlast;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // shadow registers and framing state of the predictor
  logic [7:0] sh_flag;
  logic [7:0] sh_escape;
  logic [7:0] sh_mask;
  logic [15:0] sh_poly;
  logic sh_big;
  logic [15:0] crc_acc;
  logic frame_open;

  line_rec_t run_buf [0:7];
  int run_len;
  line_rec_t line_q [$];

  int err_cnt = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  stim_row_t dir_tab [$] = '{
    // default markers straight after reset
    '{ROW_ITEM, 8'h00, 1'b0, 3'd0, 16'h0000, 3'd2, 32'h0000_007E},
    '{ROW_ITEM, 8'h7E, 1'b0, 3'd0, 16'h0000, 3'd2, 32'h0000_5E7D},
    '{ROW_ITEM, 8'h7D, 1'b0, 3'd0, 16'h0000, 3'd2, 32'h0000_5D7D},
    '{ROW_ITEM, 8'hFF, 1'b0, 3'd0, 16'h0000, 3'd1, 32'h0000_00FF},
    '{ROW_ITEM, 8'h5A, 1'b1, 3'd0, 16'h0000, 3'd0, 32'h0},
    // single-byte packet whose byte needs escaping
    '{ROW_ITEM, 8'h7E, 1'b1, 3'd0, 16'h0000, 3'd0, 32'h0},
    '{ROW_CFG,  8'h00, 1'b0, CFG_CRC_BIG_END, 16'h0001, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h00, 1'b1, 3'd0, 16'h0000, 3'd0, 32'h0},
    '{ROW_ITEM, 8'hFF, 1'b1, 3'd0, 16'h0000, 3'd0, 32'h0},
    // extreme markers, full mask, all-ones polynomial
    '{ROW_CFG,  8'h00, 1'b0, CFG_FLAG_VALUE, 16'h0000, 3'd0, 32'h0},
    '{ROW_CFG,  8'h00, 1'b0, CFG_ESCAPE_VALUE, 16'h00FF, 3'd0, 32'h0},
    '{ROW_CFG,  8'h00, 1'b0, CFG_ESCAPE_MASK, 16'h00FF, 3'd0, 32'h0},
    '{ROW_CFG,  8'h00, 1'b0, CFG_CRC_POLY, 16'hFFFF, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h80, 1'b0, 3'd0, 16'h0000, 3'd2, 32'h0000_8000},
    '{ROW_ITEM, 8'hFF, 1'b0, 3'd0, 16'h0000, 3'd2, 32'h0000_00FF},
    '{ROW_ITEM, 8'h00, 1'b0, 3'd0, 16'h0000, 3'd2, 32'h0000_FFFF},
    '{ROW_ITEM, 8'h12, 1'b1, 3'd0, 16'h0000, 3'd0, 32'h0},
    // flag equal to escape with a zero mask
    '{ROW_CFG,  8'h00, 1'b0, CFG_FLAG_VALUE, 16'hA355, 3'd0, 32'h0},
    '{ROW_CFG,  8'h00, 1'b0, CFG_ESCAPE_VALUE, 16'h0055, 3'd0, 32'h0},
    '{ROW_CFG,  8'h00, 1'b0, CFG_ESCAPE_MASK, 16'h0000, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h55, 1'b0, 3'd0, 16'h0000, 3'd3, 32'h0055_5555},
    '{ROW_ITEM, 8'h55, 1'b1, 3'd0, 16'h0000, 3'd0, 32'h0},
    // writes to unused indexes must change nothing
    '{ROW_CFG,  8'h00, 1'b0, CFG_SPARE_LO, 16'hFFFF, 3'd0, 32'h0},
    '{ROW_CFG,  8'h00, 1'b0, CFG_SPARE_HI, 16'h0000, 3'd0, 32'h0},
    '{ROW_ITEM, 8'hAA, 1'b0, 3'd0, 16'h0000, 3'd0, 32'h0},
    // polynomial changed while a frame is open
    '{ROW_CFG,  8'h00, 1'b0, CFG_CRC_POLY, 16'h0000, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h34, 1'b0, 3'd0, 16'h0000, 3'd0, 32'h0},
    '{ROW_CFG,  8'h00, 1'b0, CFG_CRC_POLY, 16'h8005, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h01, 1'b1, 3'd0, 16'h0000, 3'd0, 32'h0},
    // back to the defaults
    '{ROW_CFG,  8'h00, 1'b0, CFG_FLAG_VALUE, 16'h007E, 3'd0, 32'h0},
    '{ROW_CFG,  8'h00, 1'b0, CFG_ESCAPE_VALUE, 16'h007D, 3'd0, 32'h0},
    '{ROW_CFG,  8'h00, 1'b0, CFG_ESCAPE_MASK, 16'h0020, 3'd0, 32'h0},
    '{ROW_CFG,  8'h00, 1'b0, CFG_CRC_POLY, 16'h1021, 3'd0, 32'h0},
    '{ROW_CFG,  8'h00, 1'b0, CFG_CRC_BIG_END, 16'h0000, 3'd0, 32'h0}
  };

  crc16_byte_stuffing_framer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // compare every line byte against the oldest expectation
  always @(posedge clk) begin
    line_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (line_q.size() == 0) begin
        $display("%0t: line byte with nothing pending: byte %02h end %b last %b",
                 $time, out_tdata, out_tuser, out_tlast);
        err_cnt++;
      end else begin
        want = line_q.pop_front();
        if ({out_tdata, out_tuser, out_tlast} !== want) begin
          $display("%0t: expected byte %02h end %b last %b, got byte %02h end %b last %b",
                   $time, want.line_byte, want.frame_end, want.last_of_run,
                   out_tdata, out_tuser, out_tlast);
          err_cnt++;
        end
      end
    end
  end

  // crc-16, msb first, one byte
  function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    repeat (8) c = c[15] ? ({c[14:0], 1'b0} ^ sh_poly) : {c[14:0], 1'b0};
    return c;
  endfunction

  task automatic add_raw(input logic [7:0] b, input logic fe);
    run_buf[run_len] = '{b, fe, 1'b0};
    run_len++;
  endtask

  task automatic add_stuffed(input logic [7:0] b);
    if (b == sh_flag || b == sh_escape) begin
      add_raw(sh_escape, 1'b0);
      add_raw(b ^ sh_mask, 1'b0);
    end else begin
      add_raw(b, 1'b0);
    end
  endtask

  // line bytes caused by one payload byte
  task automatic frame_byte(input logic [7:0] b, input logic l);
    run_len = 0;
    if (!frame_open) begin
      add_raw(sh_flag, 1'b0);
      crc_acc = 16'h0000;
      frame_open = 1'b1;
    end
    crc_acc = crc_next(crc_acc, b);
    add_stuffed(b);
    if (l) begin
      if (sh_big) begin
        add_stuffed(crc_acc[15:8]);
        add_stuffed(crc_acc[7:0]);
      end else begin
        add_stuffed(crc_acc[7:0]);
        add_stuffed(crc_acc[15:8]);
      end
      add_raw(sh_flag, 1'b1);
      frame_open = 1'b0;
    end
    run_buf[run_len-1].last_of_run = 1'b1;
  endtask

  task automatic quiet_cycle();
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  // drain all pending line bytes, then let the block settle
  task automatic wait_idle();
    while (line_q.size() != 0) quiet_cycle();
    repeat (SETTLE_CYCLES) quiet_cycle();
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FLAG_VALUE:   sh_flag = val[7:0];
      CFG_ESCAPE_VALUE: sh_escape = val[7:0];
      CFG_ESCAPE_MASK:  sh_mask = val[7:0];
      CFG_CRC_POLY:     sh_poly = val;
      CFG_CRC_BIG_END:  sh_big = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // one input transaction; typed bytes, where given, replace the prediction
  task automatic send(input logic [7:0] b, input logic l,
                      input logic [2:0] n_typed, input logic [31:0] typed);
    int k;
    while ($urandom_range(0, 99) < send_idle_pct) quiet_cycle();
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    frame_byte(b, l);
    if (n_typed != 0) begin
      for (k = 0; k < n_typed; k++) begin
        line_q.push_back('{typed[8*k +: 8], 1'b0, (k == n_typed - 1)});
      end
    end else begin
      for (k = 0; k < run_len; k++) line_q.push_back(run_buf[k]);
    end
  endtask

  // payload bytes biased towards the markers and the extremes
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return sh_flag;
    if (r < 30) return sh_escape;
    if (r < 35) return 8'h00;
    if (r < 40) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic shuffle_config();
    logic [7:0] f;
    logic [7:0] e;
    f = ($urandom_range(0, 2) == 0) ? RST_FLAG_VALUE : 8'($urandom);
    case ($urandom_range(0, 3))
      0: e = f;
      1: e = RST_ESCAPE_VALUE;
      default: e = 8'($urandom);
    endcase
    write_reg(CFG_FLAG_VALUE, {8'($urandom), f});
    write_reg(CFG_ESCAPE_VALUE, {8'($urandom), e});
    write_reg(CFG_ESCAPE_MASK, ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom));
    write_reg(CFG_CRC_POLY, 16'($urandom));
    write_reg(CFG_CRC_BIG_END, 16'($urandom));
    if ($urandom_range(0, 3) == 0) begin
      write_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 16'($urandom));
    end
  endtask

  // mostly whole packets, some cut short so the frame stays open
  task automatic random_phase(input int n_items);
    int sent;
    int len;
    bit cut;
    int i;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 7);
      cut = ($urandom_range(0, 9) == 0);
      for (i = 0; i < len && sent < n_items; i++) begin
        send(pick_byte(), (i == len - 1) && !cut, 3'd0, 32'h0);
        sent++;
        // sender holds off until the line side has caught up
        if (sent == n_items / 2) wait_idle();
      end
    end
  endtask

  initial begin
    int ph;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    sh_flag = RST_FLAG_VALUE;
    sh_escape = RST_ESCAPE_VALUE;
    sh_mask = RST_ESCAPE_MASK;
    sh_poly = RST_CRC_POLY;
    sh_big = RST_CRC_BIG_END;
    crc_acc = 16'h0000;
    frame_open = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        write_reg(dir_tab[r].idx, dir_tab[r].val);
      end else begin
        send(dir_tab[r].data, dir_tab[r].last, dir_tab[r].n_typed, dir_tab[r].typed);
      end
    end

    // random phases, two settings per idling mode
    for (ph = 0; ph < 8; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 62; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 62; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      shuffle_config();
      random_phase(ITEMS_PER_PHASE);
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/fcf_pkg.sv
hw/rtl/fcf_front.sv
hw/rtl/fcf_queue.sv
hw/rtl/fcf_back.sv
hw/rtl/crc16_byte_stuffing_framer.sv
tb/tb_crc16_byte_stuffing_framer.sv
